/* rtl/xlsfu_pkg.sv */
// ----------------------------------------------------------------------------
// xlsfu_pkg
// Shared types, operation codes and helpers for the logic, shift and flag unit.
// ----------------------------------------------------------------------------
`default_nettype none

package xlsfu_pkg;

  // operation codes carried in the command field
  typedef enum logic [3:0] {
    CMD_TEST  = 4'd0,
    CMD_AND   = 4'd1,
    CMD_XOR   = 4'd2,
    CMD_OR    = 4'd3,
    CMD_SAR   = 4'd4,
    CMD_SHL   = 4'd5,
    CMD_SHR   = 4'd6,
    CMD_SETCC = 4'd7,
    CMD_NOT   = 4'd8,
    CMD_ROL   = 4'd9,
    CMD_SHRD  = 4'd10
  } cmd_e;

  // condition groups selected by bits 3:1 of the condition code
  localparam logic [2:0] CC_O  = 3'd0;
  localparam logic [2:0] CC_B  = 3'd1;
  localparam logic [2:0] CC_Z  = 3'd2;
  localparam logic [2:0] CC_BE = 3'd3;
  localparam logic [2:0] CC_S  = 3'd4;
  localparam logic [2:0] CC_P  = 3'd5;
  localparam logic [2:0] CC_L  = 3'd6;
  localparam logic [2:0] CC_LE = 3'd7;

  // operand width
  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2
  } width_e;

  typedef struct packed {
    logic cf;
    logic zf;
    logic sf;
    logic of;
  } flags_t;

  // decode stage output: shifter operand and amount plus control
  typedef struct packed {
    logic [63:0] cat;
    logic [5:0]  amt;
    width_e      width;
    logic        is_logic;
    logic        is_shift;
    logic        wb;
    flags_t      flags;
  } st1_t;

  // shift stage output
  typedef struct packed {
    logic [31:0] res;
    width_e      width;
    logic        is_logic;
    logic        is_shift;
    logic        wb;
    flags_t      flags;
  } st2_t;

  // finished result
  typedef struct packed {
    logic [31:0] res;
    width_e      width;
    logic        wb;
    flags_t      flags;
  } out_t;

  function automatic width_e decode_width(input logic [2:0] bytes);
    width_e w;
    if (bytes == 3'd1) begin
      w = W8;
    end else if (bytes == 3'd2) begin
      w = W16;
    end else begin
      w = W32;
    end
    return w;
  endfunction

  function automatic logic [31:0] width_mask(input width_e w);
    logic [31:0] m;
    case (w)
      W8:      m = 32'h0000_00ff;
      W16:     m = 32'h0000_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

  function automatic logic sign_bit(input logic [31:0] v, input width_e w);
    logic s;
    case (w)
      W8:      s = v[7];
      W16:     s = v[15];
      default: s = v[31];
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* rtl/x86_logic_shift_flag_unit.sv */
// ----------------------------------------------------------------------------
// x86_logic_shift_flag_unit
// Logic, shift, rotate and SETcc execution unit with flag update.
// ----------------------------------------------------------------------------
// Usage:
//   One instruction per transaction on the slave stream (s_axis_*), carrying
//   the command, operands, operand width, condition code and incoming flags.
//   Each instruction yields exactly one transaction on the master stream
//   (m_axis_*): the width-masked result, a write-back enable and new flags.
//   Pipeline: decode/operand prep, 64-bit right funnel shifter, mask and
//   flag stage whose register drives the master stream. An accepted
//   instruction passes the stage 1, stage 2 and output registers in turn;
//   throughput is one instruction per cycle while m_axis_tready stays high.
//   Every stage has its own valid bit and holds when the stage after it is
//   full and stalled, so a stall on m_axis_tready backs up stage by stage;
//   s_axis_tready drops only once all three stages are full. Nothing is lost
//   or repeated. Reset clears all valid bits; the unit takes input right
//   after reset is released.
// ----------------------------------------------------------------------------
`default_nettype none

module x86_logic_shift_flag_unit (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // command[3:0], dest_value[35:4], src_value[67:36], src2_value[99:68],
  // operand_bytes[102:100], cond_code[106:103], cf_in[107], zf_in[108],
  // sf_in[109], of_in[110], zero pad[111]
  input  wire logic [111:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // result_value[31:0], write_back[32], cf_out[33], zf_out[34], sf_out[35],
  // of_out[36], zero pad[39:37]
  output logic [39:0]       m_axis_tdata
);

  // input field unpacking
  logic [3:0]  cmd;
  logic [31:0] dest;
  logic [31:0] src;
  logic [31:0] src2;
  logic [2:0]  bytes;
  logic [3:0]  cc;
  xlsfu_pkg::flags_t flags_in;

  assign cmd      = s_axis_tdata[3:0];
  assign dest     = s_axis_tdata[35:4];
  assign src      = s_axis_tdata[67:36];
  assign src2     = s_axis_tdata[99:68];
  assign bytes    = s_axis_tdata[102:100];
  assign cc       = s_axis_tdata[106:103];
  assign flags_in = '{cf: s_axis_tdata[107], zf: s_axis_tdata[108],
                      sf: s_axis_tdata[109], of: s_axis_tdata[110]};

  // stage enables: a stage loads when it is empty or its content moves on
  logic vld1_q, vld2_q, vld3_q;
  logic en1, en2, en3;

  assign en3 = !vld3_q || m_axis_tready;
  assign en2 = !vld2_q || en3;
  assign en1 = !vld1_q || en2;
  assign s_axis_tready = en1;

  // stage 1: decode, operand masking, logic ops, shifter setup
  xlsfu_pkg::st1_t st1_d, st1_q;
  xlsfu_pkg::width_e w;
  logic [31:0] m;
  logic [31:0] dm;
  logic [31:0] s2m;
  logic [4:0]  cnt;
  logic [4:0]  rot;
  logic [31:0] rep;
  logic        top;
  logic        cond;

  always_comb begin
    w   = xlsfu_pkg::decode_width(bytes);
    m   = xlsfu_pkg::width_mask(w);
    dm  = dest & m;
    s2m = src2 & m;
    cnt = src[4:0];
    top = xlsfu_pkg::sign_bit(dm, w);

    // rotate count modulo width and operand replicated across 32 bits
    case (w)
      xlsfu_pkg::W8: begin
        rot = {2'b00, cnt[2:0]};
        rep = {4{dm[7:0]}};
      end
      xlsfu_pkg::W16: begin
        rot = {1'b0, cnt[3:0]};
        rep = {2{dm[15:0]}};
      end
      default: begin
        rot = cnt;
        rep = dm;
      end
    endcase

    // setcc condition, parity reads as 0
    case (cc[3:1])
      xlsfu_pkg::CC_O:  cond = flags_in.of;
      xlsfu_pkg::CC_B:  cond = flags_in.cf;
      xlsfu_pkg::CC_Z:  cond = flags_in.zf;
      xlsfu_pkg::CC_BE: cond = flags_in.cf | flags_in.zf;
      xlsfu_pkg::CC_S:  cond = flags_in.sf;
      xlsfu_pkg::CC_P:  cond = 1'b0;
      xlsfu_pkg::CC_L:  cond = flags_in.sf ^ flags_in.of;
      xlsfu_pkg::CC_LE: cond = flags_in.zf | (flags_in.sf ^ flags_in.of);
      default:          cond = 1'b0;
    endcase
    cond = cond ^ cc[0];

    st1_d          = '0;
    st1_d.width    = w;
    st1_d.wb       = 1'b1;
    st1_d.flags    = flags_in;

    case (cmd)
      xlsfu_pkg::CMD_TEST: begin
        st1_d.cat      = {32'd0, dm & src};
        st1_d.wb       = 1'b0;
        st1_d.is_logic = 1'b1;
      end
      xlsfu_pkg::CMD_AND: begin
        st1_d.cat      = {32'd0, dm & src};
        st1_d.is_logic = 1'b1;
      end
      xlsfu_pkg::CMD_XOR: begin
        st1_d.cat      = {32'd0, (dest ^ src) & m};
        st1_d.is_logic = 1'b1;
      end
      xlsfu_pkg::CMD_OR: begin
        st1_d.cat      = {32'd0, (dest | src) & m};
        st1_d.is_logic = 1'b1;
      end
      xlsfu_pkg::CMD_SAR: begin
        // sign-extend from the operand width, then fill with the sign
        st1_d.cat      = {{32{top}}, top ? (dm | ~m) : dm};
        st1_d.amt      = {1'b0, cnt};
        st1_d.is_shift = 1'b1;
      end
      xlsfu_pkg::CMD_SHL: begin
        // left shift as a right shift of {dest, 0}
        st1_d.cat      = {dest, 32'd0};
        st1_d.amt      = 6'd32 - {1'b0, cnt};
        st1_d.is_shift = 1'b1;
      end
      xlsfu_pkg::CMD_SHR: begin
        st1_d.cat      = {32'd0, dm};
        st1_d.amt      = {1'b0, cnt};
        st1_d.is_shift = 1'b1;
      end
      xlsfu_pkg::CMD_SETCC: begin
        st1_d.cat      = {63'd0, cond};
      end
      xlsfu_pkg::CMD_NOT: begin
        st1_d.cat      = {32'd0, ~dest & m};
      end
      xlsfu_pkg::CMD_ROL: begin
        // rotate left as a right funnel shift of the replicated operand
        st1_d.cat      = {rep, rep};
        st1_d.amt      = 6'd32 - {1'b0, rot};
      end
      xlsfu_pkg::CMD_SHRD: begin
        case (w)
          xlsfu_pkg::W8:  st1_d.cat = {48'd0, s2m[7:0], dm[7:0]};
          xlsfu_pkg::W16: st1_d.cat = {32'd0, s2m[15:0], dm[15:0]};
          default:        st1_d.cat = {src2, dest};
        endcase
        st1_d.amt      = {1'b0, cnt};
        st1_d.is_shift = 1'b1;
      end
      default: begin
        st1_d.wb = 1'b0;
      end
    endcase
  end

  // stage 2: funnel shifter
  xlsfu_pkg::st2_t st2_d, st2_q;

  always_comb begin
    st2_d.res      = 32'(st1_q.cat >> st1_q.amt);
    st2_d.width    = st1_q.width;
    st2_d.is_logic = st1_q.is_logic;
    st2_d.is_shift = st1_q.is_shift;
    st2_d.wb       = st1_q.wb;
    st2_d.flags    = st1_q.flags;
  end

  // stage 3: width mask and flag update
  xlsfu_pkg::out_t out_d, out_q;
  logic [31:0] res3;

  always_comb begin
    res3        = st2_q.res & xlsfu_pkg::width_mask(st2_q.width);
    out_d.res   = res3;
    out_d.width = st2_q.width;
    out_d.wb    = st2_q.wb;
    out_d.flags = st2_q.flags;
    if (st2_q.is_logic) begin
      out_d.flags.cf = 1'b0;
      out_d.flags.of = 1'b0;
    end
    if (st2_q.is_logic || st2_q.is_shift) begin
      out_d.flags.zf = (res3 == 32'd0);
      out_d.flags.sf = xlsfu_pkg::sign_bit(res3, st2_q.width);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      if (en1) vld1_q <= s_axis_tvalid;
      if (en2) vld2_q <= vld1_q;
      if (en3) vld3_q <= vld2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en1) st1_q <= st1_d;
    if (en2) st2_q <= st2_d;
    if (en3) out_q <= out_d;
  end

  // output transaction
  assign m_axis_tvalid = vld3_q;
  assign m_axis_tdata  = {3'b000, out_q.flags.of, out_q.flags.sf, out_q.flags.zf,
                          out_q.flags.cf, out_q.wb, out_q.res};

  // an empty first stage always takes input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld1_q |-> s_axis_tready)
    else $error("input refused while first stage is empty");

  // a blocked first stage keeps its item
  a_st1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld1_q && !en2 |=> vld1_q && $stable(st1_q))
    else $error("first stage item changed while blocked");

  // a blocked second stage keeps its item
  a_st2_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld2_q && !en3 |=> vld2_q && $stable(st2_q))
    else $error("second stage item changed while blocked");

  // results never carry bits above the operand width
  a_width_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q && (out_q.width == xlsfu_pkg::W8 || out_q.width == xlsfu_pkg::W16)
      |-> out_q.res[31:16] == 16'd0 && (out_q.width == xlsfu_pkg::W16 ||
          out_q.res[15:8] == 8'd0))
    else $error("result exceeds operand width");

endmodule

`default_nettype wire
